// ----- rtl/msbr_pkg.sv -----
// Shared types, constants and codes of the MSB-first bit reader.
package msbr_pkg;

    localparam int BUFFER_DEPTH = 4096;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int LEN_W        = 13;
    localparam int REM_W        = 16;
    localparam int NBITS_W      = 7;
    localparam int DATA_W       = 64;
    localparam int OUT_BYTES    = DATA_W / 8;
    localparam int BCNT_W       = 4;
    localparam int CFG_DATA_W   = 13;
    localparam int READ_STEPS   = OUT_BYTES + 1;
    localparam int STEP_W       = $clog2(READ_STEPS);

    localparam logic [NBITS_W-1:0] MAX_BITS = NBITS_W'(DATA_W);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic CFG_LENGTH = 1'b0;
    localparam logic CFG_MODE   = 1'b1;

    typedef struct packed {
        logic              action;
        logic [11:0]       load_address;
        logic [7:0]        load_byte;
        logic [6:0]        bit_count;
    } t_in_word;

    typedef struct packed {
        logic [63:0]       read_data;
        logic [3:0]        byte_count;
        logic [15:0]       bits_remaining;
        logic              overrun;
    } t_out_word;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic [ADDR_W-1:0] rd_addr;
        logic              prev_en;
        logic [2:0]        shift;
    } t_fetch_ctl;

    typedef struct packed {
        logic               clear;
        logic               shift_en;
        logic [2:0]         byte_idx;
        logic [NBITS_W-1:0] nbits;
    } t_pack_ctl;

endpackage

// ----- rtl/msbr_fetch.sv -----
// Byte buffer memory with one read port and the byte aligner behind it.
module msbr_fetch (
    input  logic               i_clk,
    input  msbr_pkg::t_fetch_ctl i_ctl,
    output logic [7:0]         o_aligned
);
    import msbr_pkg::*;

    logic [7:0]  r_mem [BUFFER_DEPTH];
    logic [7:0]  r_rd;
    logic [7:0]  r_prev;
    logic [15:0] window;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
        r_rd <= r_mem[i_ctl.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.prev_en) begin
            r_prev <= r_rd;
        end
    end

    // The previous byte and the current byte form a 16-bit window; shifting
    // by the bit offset brings the next eight stream bits to the top.
    always_comb begin
        window    = {r_prev, r_rd} << i_ctl.shift;
        o_aligned = window[15:8];
    end

endmodule

// ----- rtl/msbr_pack.sv -----
// Output shift register that collects aligned bytes into the read word.
module msbr_pack (
    input  logic                i_clk,
    input  msbr_pkg::t_pack_ctl i_ctl,
    input  logic [7:0]          i_aligned,
    output logic [63:0]         o_data
);
    import msbr_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic [3:0]        full_bytes;
    logic [2:0]        part_bits;
    logic [3:0]        idx;
    logic [7:0]        out_byte;

    always_comb begin
        full_bytes = i_ctl.nbits[6:3];
        part_bits  = i_ctl.nbits[2:0];
        idx        = {1'b0, i_ctl.byte_idx};
        out_byte   = '0;
        // Whole bytes pass as they are; the trailing partial byte keeps its
        // top bits, moved down to the low end.
        if (idx < full_bytes) begin
            out_byte = i_aligned;
        end else if (idx == full_bytes && part_bits != 3'd0) begin
            out_byte = i_aligned >> (4'd8 - {1'b0, part_bits});
        end
        n_data = r_data;
        if (i_ctl.clear) begin
            n_data = '0;
        end else if (i_ctl.shift_en) begin
            n_data = {out_byte, r_data[DATA_W-1:8]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ----- rtl/msb_first_bit_reader.sv -----
// Top level of the MSB-first bit reader: control, position state and config.
//
//   channel   signals                          handshake
//   input     start, busy, i_word              word taken when start=1, busy=0
//   result    o_valid, o_word                  one-cycle strobe, no back-pressure
//   config    i_cfg_we, i_cfg_index, i_cfg_data write taken when i_cfg_we=1
//
// A load word writes one byte into the 4096-byte buffer; its result comes out
// in the cycle after acceptance. A read word that is empty, blocked by mode or
// overruns also answers in the cycle after acceptance. A read that delivers data
// passes through the read state, where the single byte-wide buffer read port
// fetches nine bytes, one per cycle, and the result register follows.
// Reset is synchronous and active low; it zeroes position and offset and sets
// the length to zero and the mode to on, while the buffer contents stay
// undefined until loaded.
// Results cannot be held off, so the block never stalls on the output side.
module msb_first_bit_reader (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  msbr_pkg::t_in_word    i_word,
    output logic                  o_valid,
    output msbr_pkg::t_out_word   o_word,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [msbr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import msbr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [LEN_W-1:0]    r_pos, n_pos;
    logic [2:0]          r_off, n_off;
    logic [LEN_W-1:0]    r_length;
    logic                r_mode;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [2:0]          r_sh, n_sh;
    logic [NBITS_W-1:0]  r_nbits, n_nbits;
    logic                r_valid, n_valid;
    logic [BCNT_W-1:0]   r_bytes, n_bytes;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic                r_over, n_over;

    logic [LEN_W-1:0]    eff_len;
    logic [REM_W-1:0]    total_bits;
    logic [REM_W-1:0]    used_bits;
    logic [REM_W-1:0]    rem_bits;
    logic [NBITS_W-1:0]  req_bits;
    logic [REM_W-1:0]    end_bits;
    logic                accept;
    logic                last_step;

    t_fetch_ctl          fetch_ctl;
    t_pack_ctl           pack_ctl;
    logic [7:0]          aligned;
    logic [DATA_W-1:0]   pack_data;

    msbr_fetch u_fetch (
        .i_clk     (i_clk),
        .i_ctl     (fetch_ctl),
        .o_aligned (aligned)
    );

    msbr_pack u_pack (
        .i_clk     (i_clk),
        .i_ctl     (pack_ctl),
        .i_aligned (aligned),
        .o_data    (pack_data)
    );

    // Unread bits: the effective length in bits minus the consumed bits,
    // floored at zero when the length was lowered below the position.
    always_comb begin
        eff_len    = (r_length > LEN_W'(BUFFER_DEPTH)) ? LEN_W'(BUFFER_DEPTH) : r_length;
        total_bits = {eff_len, 3'b000};
        used_bits  = {r_pos, r_off};
        rem_bits   = (used_bits >= total_bits) ? '0 : total_bits - used_bits;
        req_bits   = (i_word.bit_count > MAX_BITS) ? MAX_BITS : i_word.bit_count;
        end_bits   = used_bits + REM_W'(req_bits);
    end

    assign accept    = start && !busy;
    assign busy      = (r_state == ST_READ);
    assign last_step = (r_step == STEP_W'(READ_STEPS - 1));

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_off   = r_off;
        n_step  = r_step;
        n_addr  = r_addr;
        n_sh    = r_sh;
        n_nbits = r_nbits;
        n_valid = 1'b0;
        n_bytes = r_bytes;
        n_rem   = r_rem;
        n_over  = r_over;

        fetch_ctl.wr_en   = 1'b0;
        fetch_ctl.wr_addr = i_word.load_address;
        fetch_ctl.wr_data = i_word.load_byte;
        fetch_ctl.rd_addr = r_pos[ADDR_W-1:0];
        fetch_ctl.prev_en = 1'b0;
        fetch_ctl.shift   = r_sh;

        pack_ctl.clear    = 1'b0;
        pack_ctl.shift_en = 1'b0;
        pack_ctl.byte_idx = 3'(r_step - STEP_W'(1));
        pack_ctl.nbits    = r_nbits;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    // Every word clears the output word; only a delivering
                    // read fills it again.
                    pack_ctl.clear = 1'b1;
                    n_bytes        = '0;
                    n_over         = 1'b0;
                    n_rem          = rem_bits;
                    if (i_word.action == ACT_LOAD) begin
                        fetch_ctl.wr_en = 1'b1;
                        n_valid         = 1'b1;
                    end else if (req_bits == '0 || !r_mode) begin
                        n_valid = 1'b1;
                    end else if (REM_W'(req_bits) > rem_bits) begin
                        n_over  = 1'b1;
                        n_valid = 1'b1;
                    end else begin
                        // The first byte is being fetched now; the position
                        // moves ahead at once, the old offset is kept for
                        // alignment.
                        n_state = ST_READ;
                        n_step  = '0;
                        n_addr  = r_pos[ADDR_W-1:0] + ADDR_W'(1);
                        n_sh    = r_off;
                        n_nbits = req_bits;
                        n_pos   = end_bits[REM_W-1:3];
                        n_off   = end_bits[2:0];
                    end
                end
            end
            ST_READ: begin
                fetch_ctl.rd_addr = r_addr;
                fetch_ctl.prev_en = 1'b1;
                pack_ctl.shift_en = (r_step != '0);
                n_addr            = r_addr + ADDR_W'(1);
                n_step            = r_step + STEP_W'(1);
                if (last_step) begin
                    n_state = ST_IDLE;
                    n_valid = 1'b1;
                    n_bytes = BCNT_W'(({1'b0, r_nbits} + 8'd7) >> 3);
                    n_rem   = rem_bits;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pos    <= '0;
            r_off    <= '0;
            r_length <= '0;
            r_mode   <= 1'b1;
            r_step   <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_off   <= n_off;
            r_step  <= n_step;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LENGTH: r_length <= i_cfg_data[LEN_W-1:0];
                    CFG_MODE:   r_mode   <= i_cfg_data[0];
                    default:    r_mode   <= r_mode;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_sh    <= n_sh;
        r_nbits <= n_nbits;
        r_bytes <= n_bytes;
        r_rem   <= n_rem;
        r_over  <= n_over;
    end

    assign o_valid               = r_valid;
    assign o_word.read_data      = pack_data;
    assign o_word.byte_count     = r_bytes;
    assign o_word.bits_remaining = r_rem;
    assign o_word.overrun        = r_over;

endmodule
